// ----- src/assert_macros.svh -----
// Assertion macros used by the checker module.
// The macros expect a signal named clk, and ASSERT_CLK also rst_n, in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is active
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Clocked assertion, checked during reset as well
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- src/i2crtm_pkg.sv -----
// Shared types and codes for the I2C register transaction master.
// No dependencies; every other source file but assert_macros.svh uses this package.
package i2crtm_pkg;

    typedef logic [2:0]  op_t;
    typedef logic [6:0]  addr7_t;
    typedef logic [7:0]  byte_t;
    typedef logic [15:0] length_t;
    typedef logic [17:0] limit_t;
    typedef logic [2:0]  action_t;
    typedef logic [2:0]  status_t;

    localparam op_t OP_BEGIN_WR = 3'd0;
    localparam op_t OP_BEGIN_RD = 3'd1;
    localparam op_t OP_DATA     = 3'd2;
    localparam op_t OP_RESP     = 3'd3;
    localparam op_t OP_TICK     = 3'd4;

    localparam action_t ACT_NONE    = 3'd0;
    localparam action_t ACT_START   = 3'd1;
    localparam action_t ACT_SEND    = 3'd2;
    localparam action_t ACT_RX_ACK  = 3'd3;
    localparam action_t ACT_RX_NACK = 3'd4;
    localparam action_t ACT_STOP    = 3'd5;

    localparam status_t ST_PENDING = 3'd0;
    localparam status_t ST_OK      = 3'd1;
    localparam status_t ST_NACK    = 3'd2;
    localparam status_t ST_TIMEOUT = 3'd3;
    localparam status_t ST_INVALID = 3'd4;

    localparam limit_t WAIT_LIMIT_RESET = 18'd200000;

    // Result queue geometry
    localparam int QDEPTH = 4;
    localparam int QAW    = 2;
    localparam int QCW    = 3;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_FREE,
        PH_START,
        PH_ADDR_W,
        PH_REG,
        PH_NEED,
        PH_WDATA,
        PH_RSTART,
        PH_ADDR_R,
        PH_RDATA
    } phase_t;

    typedef struct packed {
        action_t action;
        byte_t   bus_byte;
        byte_t   read_byte;
        logic    read_valid;
        status_t status;
        logic    done_res;
        logic    last;
    } res_t;

    // Results produced by one step: count of 0, 1 or 2, in order
    typedef struct packed {
        logic [1:0] cnt;
        res_t       first;
        res_t       second;
    } push_t;

endpackage

// ----- src/i2crtm_ifs.sv -----
// Channel interfaces of the I2C register transaction master.
// Depends on i2crtm_pkg for field types.
interface i2crtm_in_if;
    logic                 valid;
    logic                 ready;
    i2crtm_pkg::op_t      op;
    i2crtm_pkg::addr7_t   addr7;
    i2crtm_pkg::byte_t    reg_index;
    i2crtm_pkg::length_t  length;
    i2crtm_pkg::byte_t    data_byte;
    logic                 slave_ack;
    logic                 bus_busy;

    modport source (output valid, op, addr7, reg_index, length, data_byte, slave_ack,
                    bus_busy, input ready);
    modport sink   (input valid, op, addr7, reg_index, length, data_byte, slave_ack,
                    bus_busy, output ready);
endinterface

interface i2crtm_out_if;
    logic                 valid;
    logic                 ready;
    i2crtm_pkg::action_t  action;
    i2crtm_pkg::byte_t    bus_byte;
    i2crtm_pkg::byte_t    read_byte;
    logic                 read_valid;
    i2crtm_pkg::status_t  status;
    logic                 done_res;
    logic                 last;

    modport source (output valid, action, bus_byte, read_byte, read_valid, status,
                    done_res, last, input ready);
    modport sink   (input valid, action, bus_byte, read_byte, read_valid, status,
                    done_res, last, output ready);
endinterface

interface i2crtm_cfg_if;
    logic                 valid;
    logic                 ready;
    i2crtm_pkg::limit_t   data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ----- src/i2c_register_transaction_master.sv -----
// Top level of the I2C register transaction master.
// Depends on i2crtm_pkg, the channel interfaces, i2crtm_core and i2crtm_res_queue.
//
// Usage:
//   req carries events: begin write, begin read, host data byte, bus
//   response and tick. Each accepted event yields zero, one or two results.
//   rsp carries results (bus action, byte to send, received byte, status,
//   done and last flags). last marks the final result of one event.
//   cfg writes the wait limit in ticks; write it only while idle.
// Timing:
//   An event is held in the input register, then the step logic pushes its
//   results into a four-entry result queue, and the first result shows on
//   rsp once the queue has registered it. One event per cycle is taken as
//   long as the queue has room for two results; the rsp side drains one
//   result per cycle while rsp.ready is high, which sets the sustained
//   rate.
// Reset:
//   Phase returns to idle, counters clear, wait limit returns to 200000 and
//   the queue empties. If rsp stalls, the queue fills and req.ready drops.
module i2c_register_transaction_master (
    input  logic          clk,
    input  logic          rst_n,
    i2crtm_in_if.sink     req,
    i2crtm_out_if.source  rsp,
    i2crtm_cfg_if.sink    cfg
);
    import i2crtm_pkg::*;

    push_t push;
    logic  room;

    i2crtm_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cfg   (cfg),
        .room  (room),
        .push  (push)
    );

    i2crtm_res_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .room  (room),
        .rsp   (rsp)
    );

endmodule

// ----- src/i2crtm_core.sv -----
// Input register, sequencer state and one-step transition logic.
// Depends on i2crtm_pkg and the channel interfaces.
module i2crtm_core (
    input  logic                clk,
    input  logic                rst_n,
    i2crtm_in_if.sink           req,
    i2crtm_cfg_if.sink          cfg,
    input  logic                room,
    output i2crtm_pkg::push_t   push
);
    import i2crtm_pkg::*;

    logic     in_valid_reg;
    op_t      op_reg;
    addr7_t   addr7_reg;
    byte_t    reg_index_reg;
    length_t  length_reg;
    byte_t    data_byte_reg;
    logic     slave_ack_reg;
    logic     bus_busy_reg;

    phase_t   phase_reg, phase_next;
    logic     is_read_reg, is_read_next;
    addr7_t   addr_reg, addr_next;
    byte_t    index_reg, index_next;
    length_t  left_reg, left_next;
    limit_t   ticks_reg, ticks_next;
    limit_t   limit_reg;

    logic     fire;
    length_t  left_dec;
    limit_t   tick_inc;
    length_t  rx_left;
    res_t     r0, r1;
    logic [1:0] cnt;

    assign fire      = in_valid_reg && room;
    assign req.ready = !in_valid_reg || room;
    assign cfg.ready = 1'b1;
    assign left_dec  = left_reg - 16'd1;
    assign tick_inc  = ticks_reg + 18'd1;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            in_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            op_reg        <= req.op;
            addr7_reg     <= req.addr7;
            reg_index_reg <= req.reg_index;
            length_reg    <= req.length;
            data_byte_reg <= req.data_byte;
            slave_ack_reg <= req.slave_ack;
            bus_busy_reg  <= req.bus_busy;
        end
    end

    // Sequencer state and limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            is_read_reg <= 1'b0;
            addr_reg    <= '0;
            index_reg   <= '0;
            left_reg    <= '0;
            ticks_reg   <= '0;
            limit_reg   <= WAIT_LIMIT_RESET;
        end
        else
        begin
            phase_reg   <= phase_next;
            is_read_reg <= is_read_next;
            addr_reg    <= addr_next;
            index_reg   <= index_next;
            left_reg    <= left_next;
            ticks_reg   <= ticks_next;
            if (cfg.valid && cfg.ready)
            begin
                limit_reg <= cfg.data;
            end
        end
    end

    always_comb
    begin
        phase_next   = phase_reg;
        is_read_next = is_read_reg;
        addr_next    = addr_reg;
        index_next   = index_reg;
        left_next    = left_reg;
        ticks_next   = ticks_reg;
        cnt          = 2'd0;
        r0           = '0;
        r1           = '0;
        rx_left      = left_reg;

        if (fire)
        begin
            unique case (op_reg)
                OP_BEGIN_WR, OP_BEGIN_RD:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        if (op_reg == OP_BEGIN_RD && length_reg == '0)
                        begin
                            cnt         = 2'd1;
                            r0.status   = ST_INVALID;
                            r0.done_res = 1'b1;
                            ticks_next  = '0;
                        end
                        else
                        begin
                            is_read_next = (op_reg == OP_BEGIN_RD);
                            addr_next    = addr7_reg;
                            index_next   = reg_index_reg;
                            left_next    = length_reg;
                            phase_next   = PH_FREE;
                            ticks_next   = '0;
                        end
                    end
                end
                OP_DATA:
                begin
                    if (phase_reg == PH_NEED)
                    begin
                        left_next   = left_dec;
                        phase_next  = PH_WDATA;
                        ticks_next  = '0;
                        cnt         = 2'd1;
                        r0.action   = ACT_SEND;
                        r0.bus_byte = data_byte_reg;
                    end
                end
                OP_RESP:
                begin
                    priority if (phase_reg == PH_FREE)
                    begin
                        if (!bus_busy_reg)
                        begin
                            phase_next = PH_START;
                            ticks_next = '0;
                            cnt        = 2'd1;
                            r0.action  = ACT_START;
                        end
                    end
                    else if (phase_reg == PH_RDATA)
                    begin
                        left_next     = left_dec;
                        ticks_next    = '0;
                        r0.read_byte  = data_byte_reg;
                        r0.read_valid = 1'b1;
                        if (left_dec == '0)
                        begin
                            phase_next  = PH_IDLE;
                            cnt         = 2'd1;
                            r0.action   = ACT_NONE;
                            r0.status   = ST_OK;
                            r0.done_res = 1'b1;
                        end
                        else if (left_dec > 16'd1)
                        begin
                            cnt       = 2'd1;
                            r0.action = ACT_RX_ACK;
                        end
                        else
                        begin
                            cnt       = 2'd2;
                            r0.action = ACT_RX_NACK;
                            r1.action = ACT_STOP;
                        end
                    end
                    else if (phase_reg == PH_IDLE || phase_reg == PH_NEED)
                    begin
                        cnt = 2'd0;
                    end
                    else if (!slave_ack_reg)
                    begin
                        phase_next  = PH_IDLE;
                        ticks_next  = '0;
                        cnt         = 2'd1;
                        r0.action   = ACT_STOP;
                        r0.status   = ST_NACK;
                        r0.done_res = 1'b1;
                    end
                    else
                    begin
                        ticks_next = '0;
                        unique case (phase_reg)
                            PH_START:
                            begin
                                phase_next  = PH_ADDR_W;
                                cnt         = 2'd1;
                                r0.action   = ACT_SEND;
                                r0.bus_byte = {addr_reg, 1'b0};
                            end
                            PH_ADDR_W:
                            begin
                                phase_next  = PH_REG;
                                cnt         = 2'd1;
                                r0.action   = ACT_SEND;
                                r0.bus_byte = index_reg;
                            end
                            PH_REG, PH_WDATA:
                            begin
                                if (phase_reg == PH_REG && is_read_reg)
                                begin
                                    phase_next = PH_RSTART;
                                    cnt        = 2'd1;
                                    r0.action  = ACT_START;
                                end
                                else if (left_reg == '0)
                                begin
                                    phase_next  = PH_IDLE;
                                    cnt         = 2'd1;
                                    r0.action   = ACT_STOP;
                                    r0.status   = ST_OK;
                                    r0.done_res = 1'b1;
                                end
                                else
                                begin
                                    phase_next = PH_NEED;
                                end
                            end
                            PH_RSTART:
                            begin
                                phase_next  = PH_ADDR_R;
                                cnt         = 2'd1;
                                r0.action   = ACT_SEND;
                                r0.bus_byte = {addr_reg, 1'b1};
                            end
                            PH_ADDR_R:
                            begin
                                phase_next = PH_RDATA;
                                rx_left    = left_reg;
                                if (rx_left > 16'd1)
                                begin
                                    cnt       = 2'd1;
                                    r0.action = ACT_RX_ACK;
                                end
                                else
                                begin
                                    cnt       = 2'd2;
                                    r0.action = ACT_RX_NACK;
                                    r1.action = ACT_STOP;
                                end
                            end
                            default:
                            begin
                                phase_next = PH_IDLE;
                            end
                        endcase
                    end
                end
                OP_TICK:
                begin
                    priority if (phase_reg == PH_IDLE || phase_reg == PH_NEED)
                    begin
                        cnt = 2'd0;
                    end
                    else if (phase_reg == PH_FREE && !bus_busy_reg)
                    begin
                        phase_next = PH_START;
                        ticks_next = '0;
                        cnt        = 2'd1;
                        r0.action  = ACT_START;
                    end
                    else
                    begin
                        ticks_next = tick_inc;
                        if (!(tick_inc < limit_reg && tick_inc != '0))
                        begin
                            phase_next  = PH_IDLE;
                            ticks_next  = '0;
                            cnt         = 2'd1;
                            r0.status   = ST_TIMEOUT;
                            r0.done_res = 1'b1;
                            // No STOP before a START or after the final receive's STOP
                            if (phase_reg == PH_FREE
                                || (phase_reg == PH_RDATA && left_reg <= 16'd1))
                            begin
                                r0.action = ACT_NONE;
                            end
                            else
                            begin
                                r0.action = ACT_STOP;
                            end
                        end
                    end
                end
                default:
                begin
                    cnt = 2'd0;
                end
            endcase
        end

        // Mark the last result of this event
        if (cnt == 2'd1)
        begin
            r0.last = 1'b1;
        end
        else if (cnt == 2'd2)
        begin
            r1.last = 1'b1;
        end

        push.cnt    = cnt;
        push.first  = r0;
        push.second = r1;
    end

endmodule

// ----- src/i2crtm_res_queue.sv -----
// Result queue: takes up to two results a cycle, hands out one while rsp.ready is high.
// Depends on i2crtm_pkg and the output channel interface.
module i2crtm_res_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  i2crtm_pkg::push_t  push,
    output logic               room,
    i2crtm_out_if.source       rsp
);
    import i2crtm_pkg::*;

    res_t            mem_reg [QDEPTH];
    logic [QAW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0]  count_reg, count_next;
    logic [QAW-1:0]  wr_ptr_inc;
    logic            pop;
    res_t            head;

    assign pop        = rsp.valid && rsp.ready;
    assign room       = (count_reg <= QCW'(QDEPTH - 2));
    assign wr_ptr_inc = wr_ptr_reg + QAW'(1);
    assign head       = mem_reg[rd_ptr_reg];

    assign rsp.valid      = (count_reg != '0);
    assign rsp.action     = head.action;
    assign rsp.bus_byte   = head.bus_byte;
    assign rsp.read_byte  = head.read_byte;
    assign rsp.read_valid = head.read_valid;
    assign rsp.status     = head.status;
    assign rsp.done_res   = head.done_res;
    assign rsp.last       = head.last;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QAW'(push.cnt);
        rd_ptr_next = pop ? rd_ptr_reg + QAW'(1) : rd_ptr_reg;
        count_next  = count_reg + QCW'(push.cnt) - QCW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.first;
        end
        if (push.cnt == 2'd2)
        begin
            mem_reg[wr_ptr_inc] <= push.second;
        end
    end

endmodule

// ----- src/i2crtm_checker.sv -----
// Port-level checks for the I2C register transaction master, with its bind.
// Depends on i2crtm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module i2crtm_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 rsp_valid,
    input  logic                 rsp_ready,
    input  i2crtm_pkg::action_t  action,
    input  i2crtm_pkg::byte_t    bus_byte,
    input  i2crtm_pkg::byte_t    read_byte,
    input  logic                 read_valid,
    input  i2crtm_pkg::status_t  status,
    input  logic                 done_res,
    input  logic                 last
);
    import i2crtm_pkg::*;

    logic  stalled;
    logic  rx_action;
    res_t  head;

    assign stalled   = rsp_valid && !rsp_ready;
    assign rx_action = (action == ACT_NONE) || (action == ACT_RX_ACK)
                       || (action == ACT_RX_NACK);
    assign head      = {action, bus_byte, read_byte, read_valid, status, done_res, last};

    `ASSERT_CLK(a_rsp_hold, stalled |=> rsp_valid && $stable(head), "result changed while stalled")
    `ASSERT_CLK(a_done_last, rsp_valid && done_res |-> last, "done result not marked last")
    `ASSERT_CLK(a_byte_send, rsp_valid && action != ACT_SEND |-> bus_byte == '0, "byte without send")
    `ASSERT_CLK(a_rx_action, rsp_valid && read_valid |-> rx_action, "received byte with wrong action")
    `ASSERT_CLK(a_rx_byte, rsp_valid && !read_valid |-> read_byte == '0, "read byte without flag")

endmodule

bind i2c_register_transaction_master i2crtm_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .action     (rsp.action),
    .bus_byte   (rsp.bus_byte),
    .read_byte  (rsp.read_byte),
    .read_valid (rsp.read_valid),
    .status     (rsp.status),
    .done_res   (rsp.done_res),
    .last       (rsp.last)
);

// ----- dv/tb.sv -----
// Testbench for i2c_register_transaction_master: drives host, bus and tick events,
// predicts the bus action sequence and checks every result in order.
// Depends on i2crtm_pkg and the channel interfaces in i2crtm_ifs.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import i2crtm_pkg::*;

    // Op codes that the block must ignore
    localparam op_t OP_SPARE_LO = 3'd5;
    localparam op_t OP_SPARE_HI = 3'd7;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_EVENTS = 50;

    typedef struct packed {
        op_t     op;
        addr7_t  addr7;
        byte_t   reg_index;
        length_t length;
        byte_t   data_byte;
        logic    slave_ack;
        logic    bus_busy;
    } bus_event_t;

    class bus_step_scoreboard;
        limit_t  wait_limit;
        phase_t  seq_phase;
        logic    is_read;
        addr7_t  slave_addr;
        byte_t   reg_sel;
        length_t bytes_left;
        limit_t  ticks;
        res_t    step_actions[$];
        res_t    actions_due[$];
        int      errors;

        function new();
            wait_limit = WAIT_LIMIT_RESET;
            seq_phase  = PH_IDLE;
            is_read    = 1'b0;
            slave_addr = '0;
            reg_sel    = '0;
            bytes_left = '0;
            ticks      = '0;
            errors     = 0;
        endfunction

        function void set_limit(limit_t v);
            wait_limit = v;
        endfunction

        function void enter(phase_t p);
            seq_phase = p;
            ticks = '0;
        endfunction

        function void add(action_t act, byte_t bbyte, byte_t rbyte, logic rvalid,
                          status_t st, logic done);
            res_t r;
            r.action     = act;
            r.bus_byte   = bbyte;
            r.read_byte  = rbyte;
            r.read_valid = rvalid;
            r.status     = st;
            r.done_res   = done;
            r.last       = 1'b0;
            step_actions.push_back(r);
        endfunction

        function void close(action_t act, status_t st);
            enter(PH_IDLE);
            add(act, '0, '0, 1'b0, st, 1'b1);
        endfunction

        // ACK while more than one byte remains, else NACK followed by STOP
        function void receive_next(byte_t rbyte, logic rvalid);
            if (bytes_left > 1)
            begin
                add(ACT_RX_ACK, '0, rbyte, rvalid, ST_PENDING, 1'b0);
            end
            else
            begin
                add(ACT_RX_NACK, '0, rbyte, rvalid, ST_PENDING, 1'b0);
                add(ACT_STOP, '0, '0, 1'b0, ST_PENDING, 1'b0);
            end
        endfunction

        function void on_response(bus_event_t ev);
            if (seq_phase == PH_FREE)
            begin
                if (!ev.bus_busy)
                begin
                    enter(PH_START);
                    add(ACT_START, '0, '0, 1'b0, ST_PENDING, 1'b0);
                end
                return;
            end
            if (seq_phase == PH_RDATA)
            begin
                bytes_left = bytes_left - 1'b1;
                if (bytes_left == 0)
                begin
                    enter(PH_IDLE);
                    add(ACT_NONE, '0, ev.data_byte, 1'b1, ST_OK, 1'b1);
                end
                else
                begin
                    ticks = '0;
                    receive_next(ev.data_byte, 1'b1);
                end
                return;
            end
            if (seq_phase == PH_IDLE || seq_phase == PH_NEED)
                return;
            if (!ev.slave_ack)
            begin
                close(ACT_STOP, ST_NACK);
                return;
            end
            case (seq_phase)
                PH_START:
                begin
                    enter(PH_ADDR_W);
                    add(ACT_SEND, {slave_addr, 1'b0}, '0, 1'b0, ST_PENDING, 1'b0);
                end
                PH_ADDR_W:
                begin
                    enter(PH_REG);
                    add(ACT_SEND, reg_sel, '0, 1'b0, ST_PENDING, 1'b0);
                end
                PH_REG:
                begin
                    if (is_read)
                    begin
                        enter(PH_RSTART);
                        add(ACT_START, '0, '0, 1'b0, ST_PENDING, 1'b0);
                    end
                    else if (bytes_left == 0)
                        close(ACT_STOP, ST_OK);
                    else
                        enter(PH_NEED);
                end
                PH_WDATA:
                begin
                    if (bytes_left == 0)
                        close(ACT_STOP, ST_OK);
                    else
                        enter(PH_NEED);
                end
                PH_RSTART:
                begin
                    enter(PH_ADDR_R);
                    add(ACT_SEND, {slave_addr, 1'b1}, '0, 1'b0, ST_PENDING, 1'b0);
                end
                PH_ADDR_R:
                begin
                    enter(PH_RDATA);
                    receive_next('0, 1'b0);
                end
                default:
                    enter(PH_IDLE);
            endcase
        endfunction

        function void on_tick(bus_event_t ev);
            if (seq_phase == PH_IDLE || seq_phase == PH_NEED)
                return;
            if (seq_phase == PH_FREE && !ev.bus_busy)
            begin
                enter(PH_START);
                add(ACT_START, '0, '0, 1'b0, ST_PENDING, 1'b0);
                return;
            end
            ticks = ticks + 1'b1;
            if (ticks < wait_limit && ticks != 0)
                return;
            // No STOP while waiting for a free bus (no START yet), nor on the final receive, whose STOP is out
            if (seq_phase == PH_FREE || (seq_phase == PH_RDATA && bytes_left <= 1))
                close(ACT_NONE, ST_TIMEOUT);
            else
                close(ACT_STOP, ST_TIMEOUT);
        endfunction

        function void take_event(bus_event_t ev);
            step_actions.delete();
            case (ev.op)
                OP_BEGIN_WR, OP_BEGIN_RD:
                begin
                    if (seq_phase == PH_IDLE)
                    begin
                        if (ev.op == OP_BEGIN_RD && ev.length == 0)
                            close(ACT_NONE, ST_INVALID);
                        else
                        begin
                            is_read    = (ev.op == OP_BEGIN_RD);
                            slave_addr = ev.addr7;
                            reg_sel    = ev.reg_index;
                            bytes_left = ev.length;
                            enter(PH_FREE);
                        end
                    end
                end
                OP_DATA:
                begin
                    if (seq_phase == PH_NEED)
                    begin
                        bytes_left = bytes_left - 1'b1;
                        enter(PH_WDATA);
                        add(ACT_SEND, ev.data_byte, '0, 1'b0, ST_PENDING, 1'b0);
                    end
                end
                OP_RESP:
                    on_response(ev);
                OP_TICK:
                    on_tick(ev);
                default:
                    ;
            endcase
            if (step_actions.size() > 0)
                step_actions[step_actions.size() - 1].last = 1'b1;
            foreach (step_actions[k])
                actions_due.push_back(step_actions[k]);
        endfunction

        function void report(string what, res_t exp, res_t got);
            errors++;
            if (errors <= 10)
                $display("[%0t] %s: expected act=%0d bus=%h rd=%h rv=%b st=%0d done=%b last=%b, got act=%0d bus=%h rd=%h rv=%b st=%0d done=%b last=%b",
                         $realtime, what,
                         exp.action, exp.bus_byte, exp.read_byte, exp.read_valid,
                         exp.status, exp.done_res, exp.last,
                         got.action, got.bus_byte, got.read_byte, got.read_valid,
                         got.status, got.done_res, got.last);
        endfunction

        function void compare_result(res_t got);
            res_t exp;
            exp = '0;
            if (actions_due.size() == 0)
            begin
                report("result with nothing due", exp, got);
                return;
            end
            exp = actions_due.pop_front();
            if (got.action !== exp.action || got.bus_byte !== exp.bus_byte ||
                got.read_byte !== exp.read_byte || got.read_valid !== exp.read_valid ||
                got.status !== exp.status || got.done_res !== exp.done_res ||
                got.last !== exp.last)
                report("result mismatch", exp, got);
        endfunction

        function void account_leftovers();
            if (actions_due.size() != 0)
            begin
                errors += actions_due.size();
                $display("%0d expected results never arrived", actions_due.size());
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    i2crtm_in_if  req ();
    i2crtm_out_if rsp ();
    i2crtm_cfg_if cfg ();

    i2c_register_transaction_master uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    bus_step_scoreboard sb;
    bit no_idle;
    bit hold_request;
    int idle_cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic bus_event_t bus_event(op_t op, addr7_t a, byte_t r, length_t n,
                                             byte_t d, logic ack, logic busy);
        bus_event_t ev;
        ev.op        = op;
        ev.addr7     = a;
        ev.reg_index = r;
        ev.length    = n;
        ev.data_byte = d;
        ev.slave_ack = ack;
        ev.bus_busy  = busy;
        return ev;
    endfunction

    // Choose an event that suits the predicted phase, with a share of noise
    function automatic bus_event_t pick_event();
        bus_event_t ev;
        int unsigned roll;
        ev = bus_event(op_t'($urandom_range(7)), addr7_t'($urandom), byte_t'($urandom),
                       length_t'($urandom), byte_t'($urandom), logic'($urandom),
                       logic'($urandom));
        roll = $urandom_range(99);
        if (roll < 6)
            return ev;
        case (sb.seq_phase)
            PH_IDLE:
            begin
                ev.op = (roll < 53) ? OP_BEGIN_WR : OP_BEGIN_RD;
                if ($urandom_range(24) != 0)
                    ev.length = length_t'($urandom_range(5));
            end
            PH_FREE:
            begin
                ev.op = (roll < 40) ? OP_TICK : OP_RESP;
                ev.bus_busy = ($urandom_range(2) == 0);
            end
            PH_NEED:
                ev.op = (roll < 90) ? OP_DATA : ((roll < 95) ? OP_TICK : OP_RESP);
            PH_RDATA:
                ev.op = (roll < 85) ? OP_RESP : OP_TICK;
            default:
            begin
                ev.op = (roll < 82) ? OP_RESP : OP_TICK;
                // cut long transfers short with a slave NACK
                ev.slave_ack = (sb.bytes_left > 16) ? 1'b0 : ($urandom_range(19) != 0);
            end
        endcase
        return ev;
    endfunction

    task automatic offer(bus_event_t ev);
        if (!no_idle && $urandom_range(99) < 16)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        req.op        <= ev.op;
        req.addr7     <= ev.addr7;
        req.reg_index <= ev.reg_index;
        req.length    <= ev.length;
        req.data_byte <= ev.data_byte;
        req.slave_ack <= ev.slave_ack;
        req.bus_busy  <= ev.bus_busy;
        req.valid     <= 1'b1;
        do @(posedge clk); while (!req.ready);
        sb.take_event(ev);
    endtask

    // Drive the running transfer to its end so the block is idle again
    task automatic finish_transfer();
        bus_event_t ev;
        while (sb.seq_phase != PH_IDLE)
        begin
            ev = bus_event(OP_RESP, '0, '0, '0, byte_t'($urandom), 1'b0, 1'b0);
            if (sb.seq_phase == PH_FREE)
                ev.slave_ack = 1'b1;
            else if (sb.seq_phase == PH_NEED)
                ev.op = OP_DATA;
            offer(ev);
        end
    endtask

    task automatic settle();
        req.valid <= 1'b0;
        while (sb.actions_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(limit_t v);
        cfg.data  <= v;
        cfg.valid <= 1'b1;
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
        sb.set_limit(v);
    endtask

    // Receiver: random back-pressure, and one long hold on request
    initial
    begin
        rsp.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                rsp.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            else
                rsp.ready <= no_idle || ($urandom_range(99) >= 16);
        end
    end

    always @(posedge clk)
    begin : rsp_monitor
        res_t got;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            got.action     = rsp.action;
            got.bus_byte   = rsp.bus_byte;
            got.read_byte  = rsp.read_byte;
            got.read_valid = rsp.read_valid;
            got.status     = rsp.status;
            got.done_res   = rsp.done_res;
            got.last       = rsp.last;
            sb.compare_result(got);
        end
    end

    // Abort if no transaction completes on any channel for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready) ||
                (cfg.valid && cfg.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        limit_t limits [7];
        limit_t v;
        sb = new();
        no_idle = 1'b0;
        hold_request = 1'b0;
        idle_cycles = 0;
        limits = '{18'd1, 18'h3FFFF, 18'd0, 18'd3, 18'd2, 18'd20, 18'd5};
        rst_n         <= 1'b0;
        req.valid     <= 1'b0;
        req.op        <= OP_TICK;
        req.addr7     <= '0;
        req.reg_index <= '0;
        req.length    <= '0;
        req.data_byte <= '0;
        req.slave_ack <= 1'b0;
        req.bus_busy  <= 1'b0;
        cfg.valid     <= 1'b0;
        cfg.data      <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // stray events while idle, and an empty read
        offer(bus_event(OP_BEGIN_RD, 7'h12, 8'h34, 16'd0, 8'h00, 1'b1, 1'b0));
        offer(bus_event(OP_RESP, 7'h00, 8'h00, 16'd0, 8'hFF, 1'b1, 1'b0));
        offer(bus_event(OP_DATA, 7'h00, 8'h00, 16'd0, 8'hA5, 1'b0, 1'b0));
        offer(bus_event(OP_SPARE_HI, 7'h7F, 8'hFF, 16'hFFFF, 8'hFF, 1'b1, 1'b1));
        // empty write at top address and index, with a begin while busy
        offer(bus_event(OP_BEGIN_WR, 7'h7F, 8'hFF, 16'd0, 8'h00, 1'b0, 1'b0));
        offer(bus_event(OP_BEGIN_RD, 7'h01, 8'h01, 16'd1, 8'h00, 1'b0, 1'b0));
        offer(bus_event(OP_TICK, 7'h00, 8'h00, 16'd0, 8'h00, 1'b0, 1'b1));
        offer(bus_event(OP_RESP, 7'h00, 8'h00, 16'd0, 8'h00, 1'b1, 1'b0));
        repeat (3) offer(bus_event(OP_RESP, 7'h00, 8'h00, 16'd0, 8'h00, 1'b1, 1'b0));
        // longest write, host data wait, then a NACK on the data byte
        offer(bus_event(OP_BEGIN_WR, 7'h00, 8'h00, 16'hFFFF, 8'h00, 1'b0, 1'b0));
        offer(bus_event(OP_TICK, 7'h00, 8'h00, 16'd0, 8'h00, 1'b0, 1'b0));
        repeat (3) offer(bus_event(OP_RESP, 7'h00, 8'h00, 16'd0, 8'h00, 1'b1, 1'b0));
        offer(bus_event(OP_TICK, 7'h00, 8'h00, 16'd0, 8'h00, 1'b1, 1'b1));
        offer(bus_event(OP_RESP, 7'h00, 8'h00, 16'd0, 8'h00, 1'b1, 1'b0));
        offer(bus_event(OP_DATA, 7'h00, 8'h00, 16'd0, 8'hFF, 1'b0, 1'b0));
        offer(bus_event(OP_RESP, 7'h00, 8'h00, 16'd0, 8'h00, 1'b0, 1'b0));
        // two-byte read: ACK then NACK with STOP, slave_ack ignored on receive
        offer(bus_event(OP_BEGIN_RD, 7'h55, 8'hAA, 16'd2, 8'h00, 1'b0, 1'b0));
        repeat (6) offer(bus_event(OP_RESP, 7'h00, 8'h00, 16'd0, 8'h00, 1'b1, 1'b0));
        offer(bus_event(OP_RESP, 7'h00, 8'h00, 16'd0, 8'hFF, 1'b0, 1'b0));
        offer(bus_event(OP_RESP, 7'h00, 8'h00, 16'd0, 8'h00, 1'b1, 1'b1));
        finish_transfer();

        for (int k = 0; k < 7; k++)
        begin
            settle();
            v = (k == 5) ? limit_t'($urandom_range(1, 40)) : limits[k];
            write_limit(v);
            no_idle = (k == 3);
            hold_request = (k == 3);
            for (int j = 0; j < PHASE_EVENTS; j++)
                offer(pick_event());
            finish_transfer();
        end
        no_idle = 1'b0;

        settle();
        repeat (20) @(posedge clk);
        sb.account_leftovers();
        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
